### rtl/tlpt_pkg.sv
package tlpt_pkg;

	// Width of the byte offset inside a 4 KiB page.
	localparam int OFFSET_BITS = 12;

	// Operation selector codes on the input port; any other code is a translation.
	localparam logic [1:0] FUNC_FORCE = 2'd0;
	localparam logic [1:0] FUNC_MAP   = 2'd1;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_SKIP  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// Page table entry flag bits.
	localparam logic [OFFSET_BITS-1:0] ENT_PRESENT = 12'h001;
	localparam logic [OFFSET_BITS-1:0] ENT_RW      = 12'h002;

	// Operation class decided by the front end.
	typedef enum logic [1:0] {
		OP_FORCE = 2'd0,
		OP_MAP   = 2'd1,
		OP_XLATE = 2'd2,
		OP_RANGE = 2'd3
	} op_t;

	// One classified request as it travels through the queue.
	typedef struct packed {
		op_t         op;
		logic [31:0] va;
		logic [31:0] entry;
	} req_t;

	// One word of the page table memory.
	typedef struct packed {
		logic        present;
		logic [31:0] entry;
	} pte_t;

endpackage

### rtl/tlpt_front.sv
module tlpt_front
	import tlpt_pkg::*;
#(
	parameter int DIR_INDEX_BITS = 4
) (
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] virt_addr,
	input  logic [19:0] phys_frame,
	input  logic [11:0] map_flags,
	input  logic        clear_busy,
	input  logic        q_full,
	output logic        q_push,
	output req_t        q_item
);

	localparam logic [10:0] DIR_LIMIT = 11'(1 << DIR_INDEX_BITS);

	logic out_of_range;

	// Hold off new transactions while the queue is full or the table is being cleared.
	assign in_stall = q_full | clear_busy;
	assign q_push   = in_valid & ~in_stall;

	// A directory index beyond the table is rejected without touching any state.
	assign out_of_range = {1'b0, virt_addr[31:22]} >= DIR_LIMIT;

	// Classify the request and build the entry that a force or map would write.
	always_comb begin
		q_item.va    = virt_addr;
		q_item.entry = {phys_frame, ENT_PRESENT | ENT_RW};
		case (func)
			FUNC_FORCE: begin
				q_item.op = OP_FORCE;
			end
			FUNC_MAP: begin
				q_item.op    = OP_MAP;
				q_item.entry = {phys_frame, map_flags | ENT_PRESENT};
			end
			default: begin
				q_item.op = OP_XLATE;
			end
		endcase
		if (out_of_range) begin
			q_item.op = OP_RANGE;
		end
	end

endmodule

### rtl/tlpt_fifo.sv
module tlpt_fifo
	import tlpt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_item,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output req_t pop_item
);

	req_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign pop_valid = count_q != 2'd0;
	assign pop_item  = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### rtl/tlpt_back.sv
module tlpt_back
	import tlpt_pkg::*;
#(
	parameter int DIR_INDEX_BITS  = 4,
	parameter int PAGE_INDEX_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  req_t        req_item,
	output logic        req_pop,
	output logic        clear_busy,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] phys_addr,
	output logic [1:0]  status,
	output logic        table_created
);

	localparam int SLOT_BITS = DIR_INDEX_BITS + PAGE_INDEX_BITS;
	localparam int DEPTH     = 1 << SLOT_BITS;
	localparam int DIR_COUNT = 1 << DIR_INDEX_BITS;

	typedef enum logic [2:0] {
		S_CLEAR  = 3'b001,
		S_IDLE   = 3'b010,
		S_LOOKUP = 3'b100
	} state_t;

	state_t                     state_q;
	logic [SLOT_BITS-1:0]       clr_q;
	logic [DIR_COUNT-1:0]       dir_present_q;
	pte_t                       mem [DEPTH];
	pte_t                       rdata_q;
	req_t                       req_q;
	logic                       out_valid_q;
	logic [31:0]                phys_addr_q;
	logic [1:0]                 status_q;
	logic                       created_q;

	logic                       out_free;
	logic                       finish;
	logic [SLOT_BITS-1:0]       rd_slot;
	logic [SLOT_BITS-1:0]       cur_slot;
	logic [DIR_INDEX_BITS-1:0]  cur_dir;
	logic                       dir_hit;
	logic                       page_hit;
	logic                       wr_en;
	logic [SLOT_BITS-1:0]       wr_addr;
	pte_t                       wr_data;
	logic                       set_dir;
	logic [31:0]                res_addr;
	logic [1:0]                 res_status;
	logic                       res_created;

	assign clear_busy    = state_q == S_CLEAR;
	assign out_free      = ~out_valid_q | ~out_stall;
	assign req_pop       = (state_q == S_IDLE) & req_valid;
	assign finish        = (state_q == S_LOOKUP) & out_free;

	assign rd_slot  = {req_item.va[22 +: DIR_INDEX_BITS], req_item.va[12 +: PAGE_INDEX_BITS]};
	assign cur_dir  = req_q.va[22 +: DIR_INDEX_BITS];
	assign cur_slot = {cur_dir, req_q.va[12 +: PAGE_INDEX_BITS]};
	assign dir_hit  = dir_present_q[cur_dir];
	assign page_hit = rdata_q.present;

	assign out_valid     = out_valid_q;
	assign phys_addr     = phys_addr_q;
	assign status        = status_q;
	assign table_created = created_q;

	// Decide the result and the table update for the request under lookup.
	always_comb begin
		res_addr    = 32'd0;
		res_status  = ST_OK;
		res_created = 1'b0;
		set_dir     = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = cur_slot;
		wr_data     = '{present: 1'b1, entry: req_q.entry};
		case (req_q.op)
			OP_RANGE: begin
				res_status = ST_RANGE;
			end
			OP_XLATE: begin
				if (dir_hit && page_hit) begin
					res_addr = {rdata_q.entry[31:OFFSET_BITS], req_q.va[OFFSET_BITS-1:0]};
				end else begin
					res_status = ST_MISS;
				end
			end
			OP_FORCE: begin
				res_created = ~dir_hit;
				set_dir     = finish;
				wr_en       = finish;
			end
			default: begin
				res_created = ~dir_hit;
				set_dir     = finish;
				if (page_hit) begin
					res_status = ST_SKIP;
				end else begin
					wr_en = finish;
				end
			end
		endcase
		// The clearing pass owns the write port right after reset.
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '{present: 1'b0, entry: 32'd0};
		end
	end

	// Sequencer: clearing pass, then for each transaction a read step (S_IDLE) and a resolve step (S_LOOKUP).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			dir_present_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// A new result loads the output register; an accepted one leaves it.
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (set_dir) begin
				dir_present_q[cur_dir] <= 1'b1;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (req_pop) begin
			req_q <= req_item;
		end
		if (finish) begin
			phys_addr_q <= res_addr;
			status_q    <= res_status;
			created_q   <= res_created;
		end
	end

	// Page table memory: one registered read port, one write port.
	always_ff @(posedge clk) begin
		if (req_pop) begin
			rdata_q <= mem[rd_slot];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

### rtl/two_level_page_table_map_translate.sv
// Two-level page table with map and translate operations. The virtual
// address splits into a directory index (bits 31:22), a page index
// (bits 21:12, low PAGE_INDEX_BITS used) and a byte offset. A front end
// classifies each transaction and places it in a two-entry queue, so the
// input side keeps accepting while the back end works, until the queue
// fills. The back end handles a transaction in two steps, a table read
// (S_IDLE) and a resolve step (S_LOOKUP) that decides the result and writes
// the entry back; it takes no new transaction until the last is resolved.
// After reset the block clears the present bits of the table memory, one
// entry per cycle, for all 2^(DIR_INDEX_BITS+PAGE_INDEX_BITS) entries (16384
// with the defaults), and stalls its input until that pass is done. Results
// wait in an output register, and every transaction gives exactly one result.
module two_level_page_table_map_translate
	import tlpt_pkg::*;
#(
	parameter int DIR_INDEX_BITS  = 4,
	parameter int PAGE_INDEX_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] virt_addr,
	input  logic [19:0] phys_frame,
	input  logic [11:0] map_flags,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] phys_addr,
	output logic [1:0]  status,
	output logic        table_created
);

	logic q_full;
	logic q_push;
	req_t q_in;
	logic q_pop;
	logic q_valid;
	req_t q_out;
	logic clear_busy;

	// Front end: accepts and classifies transactions.
	tlpt_front #(
		.DIR_INDEX_BITS(DIR_INDEX_BITS)
	) u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.virt_addr (virt_addr),
		.phys_frame(phys_frame),
		.map_flags (map_flags),
		.clear_busy(clear_busy),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_in)
	);

	// Queue between the two halves.
	tlpt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.pop_valid(q_valid),
		.pop_item (q_out)
	);

	// Back end: table lookup, update and result.
	tlpt_back #(
		.DIR_INDEX_BITS (DIR_INDEX_BITS),
		.PAGE_INDEX_BITS(PAGE_INDEX_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (q_valid),
		.req_item     (q_out),
		.req_pop      (q_pop),
		.clear_busy   (clear_busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.phys_addr    (phys_addr),
		.status       (status),
		.table_created(table_created)
	);

endmodule

### sim/two_level_page_table_map_translate_tb.sv
`timescale 1ns / 1ps

module two_level_page_table_map_translate_tb;
	import tlpt_pkg::*;

	localparam int DIR_BITS   = 4;
	localparam int PAGE_BITS  = 10;
	localparam int DIR_COUNT  = 1 << DIR_BITS;
	localparam int SLOT_COUNT = 1 << (DIR_BITS + PAGE_BITS);

	// Both of the remaining selector codes ask for a translation.
	localparam logic [1:0] FUNC_XLATE     = 2'd2;
	localparam logic [1:0] FUNC_XLATE_ALT = 2'd3;

	localparam int PHASE_COUNT      = 4;
	localparam int RANDOM_PER_PHASE = 425;
	localparam int HOT_PAGES        = 24;
	localparam int DRAIN_CYCLES     = 20;
	localparam int PRINT_LIMIT      = 100;

	typedef struct {
		logic [31:0] phys_addr;
		logic [1:0]  status;
		logic        table_created;
	} xlate_result_t;

	// Mirror of the page table, with the results still owed by the block.
	class page_table_scoreboard;
		bit            dir_present[DIR_COUNT];
		bit            page_present[SLOT_COUNT];
		logic [31:0]   page_entry[SLOT_COUNT];
		xlate_result_t expected_results[$];
		int            mismatches;

		// Work out the result of one accepted transaction and update the mirror.
		function void note_request(logic [1:0] op, logic [31:0] va, logic [19:0] frame,
				logic [11:0] flags);
			xlate_result_t        res;
			logic [9:0]           dir_idx;
			logic [PAGE_BITS-1:0] page_idx;
			int                   slot;
			dir_idx = va[31:22];
			page_idx = va[OFFSET_BITS +: PAGE_BITS];
			res.phys_addr = '0;
			res.status = ST_OK;
			res.table_created = 1'b0;
			if (dir_idx >= DIR_COUNT) begin
				res.status = ST_RANGE;
			end else begin
				slot = (int'(dir_idx) << PAGE_BITS) | int'(page_idx);
				if (op != FUNC_FORCE && op != FUNC_MAP) begin
					if (!dir_present[dir_idx] || !page_present[slot])
						res.status = ST_MISS;
					else
						res.phys_addr = {page_entry[slot][31:OFFSET_BITS],
							va[OFFSET_BITS-1:0]};
				end else begin
					if (!dir_present[dir_idx]) begin
						dir_present[dir_idx] = 1'b1;
						res.table_created = 1'b1;
					end
					if (op == FUNC_MAP && page_present[slot]) begin
						res.status = ST_SKIP;
					end else begin
						if (op == FUNC_FORCE)
							page_entry[slot] = {frame, ENT_PRESENT | ENT_RW};
						else
							page_entry[slot] = {frame, flags | ENT_PRESENT};
						page_present[slot] = 1'b1;
					end
				end
			end
			expected_results.push_back(res);
		endfunction

		task report_mismatch(string msg);
			if (mismatches < PRINT_LIMIT)
				$display("%0t ns: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		// Compare one accepted result with the oldest outstanding expectation.
		task check_result(logic [31:0] pa, logic [1:0] st, logic created);
			xlate_result_t want;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing outstanding: pa=%h status=%0d",
					pa, st));
				return;
			end
			want = expected_results.pop_front();
			if (pa !== want.phys_addr)
				report_mismatch($sformatf("phys_addr %h, expected %h", pa, want.phys_addr));
			if (st !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
			if (created !== want.table_created)
				report_mismatch($sformatf("table_created %b, expected %b", created,
					want.table_created));
		endtask
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic [1:0]  func          = FUNC_FORCE;
	logic [31:0] virt_addr     = '0;
	logic [19:0] phys_frame    = '0;
	logic [11:0] map_flags     = '0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic [31:0] phys_addr;
	logic [1:0]  status;
	logic        table_created;

	int idle_pct  = 0;
	int stall_pct = 0;
	int idle_pcts[PHASE_COUNT]  = '{0, 56, 0, 28};
	int stall_pcts[PHASE_COUNT] = '{0, 0, 56, 28};

	logic [DIR_BITS+PAGE_BITS-1:0] hot_pages[HOT_PAGES];

	page_table_scoreboard sb;

	two_level_page_table_map_translate #(
		.DIR_INDEX_BITS(DIR_BITS),
		.PAGE_INDEX_BITS(PAGE_BITS)
	) i_dut (.*);

	always #5 clk = ~clk;

	function automatic bit chance(int pct);
		return $urandom_range(99) < pct;
	endfunction

	// The receiver stalls at random, changing only on the falling edge.
	always @(negedge clk) begin
		out_stall <= chance(stall_pct);
	end

	// Every result transaction is checked as it is accepted.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(phys_addr, status, table_created);
	end

	// Offer one request transaction, with random idle cycles ahead of it.
	task automatic send_request(logic [1:0] op, logic [31:0] va, logic [19:0] frame,
			logic [11:0] flags);
		while (chance(idle_pct)) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		func <= op;
		virt_addr <= va;
		phys_frame <= frame;
		map_flags <= flags;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(op, va, frame, flags);
	endtask

	// Most addresses fall on a small set of pages so that maps, hits and skips meet.
	task automatic random_request();
		logic [31:0] va;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 70)
			va = {{(10 - DIR_BITS){1'b0}}, hot_pages[$urandom_range(HOT_PAGES - 1)],
				12'($urandom)};
		else if (pick < 85)
			va = {{(10 - DIR_BITS){1'b0}}, (DIR_BITS + PAGE_BITS)'($urandom),
				12'($urandom)};
		else
			va = $urandom;
		send_request(2'($urandom_range(3)), va, 20'($urandom), 12'($urandom));
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: empty table, range errors, extremes and each outcome.
		send_request(FUNC_XLATE, 32'h0000_0000, 20'h00000, 12'h000);
		send_request(FUNC_XLATE_ALT, 32'hFFFF_FFFF, 20'hFFFFF, 12'hFFF);
		send_request(FUNC_FORCE, 32'h0000_0000, 20'hFFFFF, 12'h000);
		send_request(FUNC_XLATE, 32'h0000_0FFF, 20'h00000, 12'h000);
		send_request(FUNC_MAP, 32'h0000_0ABC, 20'h12345, 12'hFFE);
		send_request(FUNC_MAP, 32'h0000_1000, 20'h00000, 12'h000);
		send_request(FUNC_XLATE_ALT, 32'h0000_1FFF, 20'h00000, 12'h000);
		send_request(FUNC_MAP, 32'h03FF_F000, 20'hABCDE, 12'hFFF);
		send_request(FUNC_XLATE, 32'h03FF_FFFF, 20'h00000, 12'h000);
		send_request(FUNC_FORCE, 32'h03FF_F123, 20'h00000, 12'hFFF);
		send_request(FUNC_XLATE, 32'h03FF_F000, 20'h00000, 12'h000);
		send_request(FUNC_FORCE, 32'h0400_0000, 20'hFFFFF, 12'hFFF);
		send_request(FUNC_MAP, 32'hFFC0_0000, 20'hFFFFF, 12'hFFF);
		send_request(FUNC_XLATE, 32'h0000_2000, 20'h00000, 12'h000);
		send_request(FUNC_MAP, 32'h0140_5000, 20'h55555, 12'h000);
		send_request(FUNC_XLATE, 32'h0140_5AAA, 20'h00000, 12'h000);
		send_request(FUNC_FORCE, 32'h0140_5000, 20'hAAAAA, 12'h555);
		send_request(FUNC_XLATE, 32'h0140_5555, 20'h00000, 12'h000);
		send_request(FUNC_MAP, 32'h0140_5000, 20'h12345, 12'hABC);
		send_request(FUNC_XLATE, 32'h8000_0000, 20'h00000, 12'h000);

		// Random part, one phase per idling pattern.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			idle_pct = idle_pcts[p];
			stall_pct = stall_pcts[p];
			foreach (hot_pages[i])
				hot_pages[i] = (DIR_BITS + PAGE_BITS)'($urandom);
			repeat (RANDOM_PER_PHASE)
				random_request();
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog: far beyond the clearing pass after reset and the slowest run.
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
